@@ src/bcc_pkg.sv @@
package bcc_pkg;

  // configuration register indexes
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_DOUBLE_WINDOW  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_LONG_THRESHOLD = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_DEBOUNCE_TICKS = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_CLICK_COUNT    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_ACTIVE_LEVEL   = 3'd4;

  localparam int unsigned CntW     = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned EvW      = 5;

  // reset values of the configuration registers
  localparam logic [CntW-1:0] DOUBLE_WINDOW_RST  = 16'd300;
  localparam logic [CntW-1:0] LONG_THRESHOLD_RST = 16'd2000;
  localparam logic [CntW-1:0] DEBOUNCE_TICKS_RST = 16'd20;
  localparam logic [CntW-1:0] CLICK_COUNT_RST    = 16'd2;
  localparam logic            ACTIVE_LEVEL_RST   = 1'b0;

  // gap wrap constant of the original counter arithmetic
  localparam logic [CntW:0] GAP_WRAP = 17'h0FFFF;

  typedef struct packed {
    logic [CntW-1:0] double_window;
    logic [CntW-1:0] long_threshold;
    logic [CntW-1:0] debounce_ticks;
    logic [CntW-1:0] click_count;
    logic            active_level;
  } cfg_t;

  // declared msb first so that short_click lands in bit 0
  typedef struct packed {
    logic long_release;
    logic long_hold;
    logic long_click;
    logic multi_click;
    logic short_click;
  } events_t;

endpackage

@@ src/bcc_cfg.sv @@
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  // register file, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.double_window  <= DOUBLE_WINDOW_RST;
      cfg.long_threshold <= LONG_THRESHOLD_RST;
      cfg.debounce_ticks <= DEBOUNCE_TICKS_RST;
      cfg.click_count    <= CLICK_COUNT_RST;
      cfg.active_level   <= ACTIVE_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DOUBLE_WINDOW:  cfg.double_window  <= cfg_wdata;
        REG_LONG_THRESHOLD: cfg.long_threshold <= cfg_wdata;
        REG_DEBOUNCE_TICKS: cfg.debounce_ticks <= cfg_wdata;
        REG_CLICK_COUNT:    cfg.click_count    <= cfg_wdata;
        REG_ACTIVE_LEVEL:   cfg.active_level   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/bcc_core.sv @@
module bcc_core
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  logic    pin,
  input  cfg_t    cfg,
  output events_t ev
);

  logic            pressed_phase, pressed_phase_next;
  logic [CntW-1:0] debounce_count, debounce_count_next;
  logic [CntW-1:0] tick_count, tick_count_next;
  logic [CntW-1:0] release_count, release_count_next;
  logic [CntW-1:0] first_release_tick, first_release_tick_next;
  logic            long_done, long_done_next;

  logic            active;
  logic [CntW-1:0] deb_inc;
  logic [CntW:0]   gap;

  // phase logic then gap classification, one tick per step
  always_comb begin
    active                  = (pin == cfg.active_level);
    pressed_phase_next      = pressed_phase;
    debounce_count_next     = debounce_count;
    tick_count_next         = tick_count;
    release_count_next      = release_count;
    first_release_tick_next = first_release_tick;
    long_done_next          = long_done;
    deb_inc                 = debounce_count + 16'd1;
    ev                      = '0;

    if (pressed_phase || (release_count != '0)) begin
      tick_count_next = tick_count + 16'd1;
    end

    if (!pressed_phase) begin
      if (active) begin
        debounce_count_next = deb_inc;
        if (deb_inc >= cfg.debounce_ticks) begin
          debounce_count_next = '0;
          pressed_phase_next  = 1'b1;
        end
      end else begin
        debounce_count_next = '0;
      end
    end else begin
      if (active && !long_done && (tick_count_next >= cfg.long_threshold)) begin
        long_done_next = 1'b1;
        ev.long_click  = 1'b1;
      end else if (!active) begin
        if (long_done) begin
          tick_count_next    = '0;
          release_count_next = '0;
          pressed_phase_next = 1'b0;
          long_done_next     = 1'b0;
          ev.long_release    = 1'b1;
        end else begin
          pressed_phase_next = 1'b0;
          if (release_count == '0) begin
            first_release_tick_next = tick_count_next;
          end
          release_count_next = release_count + 16'd1;
        end
      end else if (long_done) begin
        ev.long_hold = 1'b1;
      end
    end

    // gap since first release, with the wrap formula
    if (tick_count_next < first_release_tick_next) begin
      gap = {1'b0, tick_count_next} + GAP_WRAP - {1'b0, first_release_tick_next};
    end else begin
      gap = {1'b0, tick_count_next} - {1'b0, first_release_tick_next};
    end

    if ((gap > {1'b0, cfg.double_window}) && (release_count_next != '0)) begin
      release_count_next      = '0;
      tick_count_next         = '0;
      first_release_tick_next = '0;
      ev.short_click          = 1'b1;
    end else if ((gap < {1'b0, cfg.double_window}) &&
                 (release_count_next == cfg.click_count)) begin
      release_count_next      = '0;
      tick_count_next         = '0;
      first_release_tick_next = '0;
      ev.multi_click          = 1'b1;
    end
  end

  // classifier state
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_phase      <= 1'b0;
      debounce_count     <= '0;
      tick_count         <= '0;
      release_count      <= '0;
      first_release_tick <= '0;
      long_done          <= 1'b0;
    end else if (step) begin
      pressed_phase      <= pressed_phase_next;
      debounce_count     <= debounce_count_next;
      tick_count         <= tick_count_next;
      release_count      <= release_count_next;
      first_release_tick <= first_release_tick_next;
      long_done          <= long_done_next;
    end
  end

endmodule

@@ src/button_click_classifier_unit.sv @@
// Button click classifier: takes one pin sample per input beat (one tick),
// debounces presses and reports short click, multi-click, long click,
// long hold and long release as flags on one output beat per input beat.
// Throughput is one beat per clock cycle while the output is not stalled. An
// accepted sample is held in the input register; the combinational classifier
// update then loads its flags into the result register, from which the result
// beat is presented. Backpressure on the output holds both registers and the
// classifier state. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata; the user must write them only while no beat is
// in flight, as the block itself does not enforce it.
module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // [0] pin_level, rest unused
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [0] short_click, [1] multi_click,
                                             // [2] long_click, [3] long_hold,
                                             // [4] long_release, rest zero
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  events_t ev;
  logic    in_valid;
  logic    in_pin;
  logic    out_free;
  logic    step;
  events_t out_ev;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline advance control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pin <= s_axis_tdata[0];
    end
  end

  bcc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .pin  (in_pin),
    .cfg  (cfg),
    .ev   (ev)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_ev <= ev;
    end
  end

  assign m_axis_tdata = {{(OutDataW-EvW){1'b0}}, out_ev};

endmodule

@@ src/bcc_checker.sv @@
module bcc_checker
  import bcc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // short and multi click exclude each other
  a_click_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("short and multi click together");

  // at most one phase event per tick
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot0(m_axis_tdata[4:2]))
    else $error("more than one phase event");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OutDataW-1:EvW] == '0))
    else $error("nonzero padding in result beat");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
